>>> rtl/assert_macros.svh
// Assertion macros used by pixel_blend_unit.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PBU_ASSERT_IMP(lbl, clk_s, rstn_s, a, b, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (a) |-> (b)) else $error(msg);
`define PBU_ASSERT_NXT(lbl, clk_s, rstn_s, a, b, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (a) |=> (b)) else $error(msg);
`else
`define PBU_ASSERT_IMP(lbl, clk_s, rstn_s, a, b, msg)
`define PBU_ASSERT_NXT(lbl, clk_s, rstn_s, a, b, msg)
`endif

`endif

>>> rtl/pbu_pkg.sv
// Types and codes of the pixel blend unit.
`default_nettype none
package pbu_pkg;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned FACTOR_W   = 4;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 4;
  localparam logic [CH_W-1:0] CH_MAX = 8'd255;

  typedef enum logic [FACTOR_W-1:0] {
    FC_ONE         = 4'd0,
    FC_ZERO        = 4'd1,
    FC_SRC         = 4'd2,
    FC_DST         = 4'd3,
    FC_ONE_M_SRC   = 4'd4,
    FC_ONE_M_DST   = 4'd5,
    FC_SRC_A       = 4'd6,
    FC_DST_A       = 4'd7,
    FC_ONE_M_SRC_A = 4'd8,
    FC_ONE_M_DST_A = 4'd9
  } factor_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MIN = 2'd2,
    OP_MAX = 2'd3
  } blend_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_COLOR = 3'd0,
    REG_DST_COLOR = 3'd1,
    REG_SRC_ALPHA = 3'd2,
    REG_DST_ALPHA = 3'd3,
    REG_BLEND_OP  = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [FACTOR_W-1:0] src_factor;
    logic [FACTOR_W-1:0] dst_factor;
    logic [OP_W-1:0]     op;
  } chan_cfg_t;

endpackage
`default_nettype wire

>>> rtl/pbu_channel.sv
// One channel: factor select, weighting by f/255, combine and clamp.
`default_nettype none
module pbu_channel (
  input  var pbu_pkg::chan_cfg_t        cfg,
  input  wire [pbu_pkg::CH_W-1:0]       sc,
  input  wire [pbu_pkg::CH_W-1:0]       dc,
  input  wire [pbu_pkg::CH_W-1:0]       sa,
  input  wire [pbu_pkg::CH_W-1:0]       da,
  output logic [pbu_pkg::CH_W-1:0]      result
);
  import pbu_pkg::*;

  logic [CH_W-1:0]   fs, fd;
  logic [CH_W-1:0]   ws, wd;
  logic [2*CH_W-1:0] ps, pd;
  logic [CH_W:0]     sum;

  function automatic logic [CH_W-1:0] factor_sel(
    input logic [FACTOR_W-1:0] code,
    input logic [CH_W-1:0] s, input logic [CH_W-1:0] d,
    input logic [CH_W-1:0] a_s, input logic [CH_W-1:0] a_d);
    logic [CH_W-1:0] f;
    unique case (code)
      FC_ONE:         f = CH_MAX;
      FC_ZERO:        f = '0;
      FC_SRC:         f = s;
      FC_DST:         f = d;
      FC_ONE_M_SRC:   f = CH_MAX - s;
      FC_ONE_M_DST:   f = CH_MAX - d;
      FC_SRC_A:       f = a_s;
      FC_DST_A:       f = a_d;
      FC_ONE_M_SRC_A: f = CH_MAX - a_s;
      FC_ONE_M_DST_A: f = CH_MAX - a_d;
      default:        f = '0;
    endcase
    return f;
  endfunction

  // floor(p / 255) for p <= 255*255
  function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] p);
    logic [2*CH_W:0] t;
    t = {1'b0, p} + {{(CH_W+1){1'b0}}, p[2*CH_W-1:CH_W]} + {{(2*CH_W){1'b0}}, 1'b1};
    return t[2*CH_W-1:CH_W];
  endfunction

  always_comb begin
    fs  = factor_sel(cfg.src_factor, sc, dc, sa, da);
    fd  = factor_sel(cfg.dst_factor, sc, dc, sa, da);
    ps  = sc * fs;
    pd  = dc * fd;
    ws  = div255(ps);
    wd  = div255(pd);
    sum = {1'b0, ws} + {1'b0, wd};
    case (cfg.op)
      OP_ADD:  result = sum[CH_W] ? CH_MAX : sum[CH_W-1:0];
      OP_SUB:  result = (ws > wd) ? (ws - wd) : '0;
      OP_MIN:  result = (ws < wd) ? ws : wd;
      default: result = (ws > wd) ? ws : wd;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/pixel_blend_unit.sv
// Top level of the pixel blend unit: config registers, input and result registers.
//
//  channel  handshake              payload
//  in       start / busy           in_src_*, in_dst_* (RGBA8 pair)
//  out      out_valid strobe       out_red, out_green, out_blue, out_alpha
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request per cycle; busy is never raised.
// After acceptance a request passes the input register, then the
// multiply / divide-by-255 / combine path into the result register.
// Synchronous active-low reset clears valids and restores register defaults.
// The receiver cannot stall; cfg_ready is always high.
`default_nettype none
`include "assert_macros.svh"
module pixel_blend_unit (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  wire [pbu_pkg::CH_W-1:0]          in_src_red,
  input  wire [pbu_pkg::CH_W-1:0]          in_src_green,
  input  wire [pbu_pkg::CH_W-1:0]          in_src_blue,
  input  wire [pbu_pkg::CH_W-1:0]          in_src_alpha,
  input  wire [pbu_pkg::CH_W-1:0]          in_dst_red,
  input  wire [pbu_pkg::CH_W-1:0]          in_dst_green,
  input  wire [pbu_pkg::CH_W-1:0]          in_dst_blue,
  input  wire [pbu_pkg::CH_W-1:0]          in_dst_alpha,
  output logic                             out_valid,
  output logic [pbu_pkg::CH_W-1:0]         out_red,
  output logic [pbu_pkg::CH_W-1:0]         out_green,
  output logic [pbu_pkg::CH_W-1:0]         out_blue,
  output logic [pbu_pkg::CH_W-1:0]         out_alpha,
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire [pbu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire [pbu_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pbu_pkg::*;

  logic [FACTOR_W-1:0] src_color_r, dst_color_r, src_alpha_f_r, dst_alpha_f_r;
  logic [OP_W-1:0]     blend_op_r;

  logic                accept;
  logic                stage_vld_r;
  logic [CH_W-1:0]     s_r [4];
  logic [CH_W-1:0]     d_r [4];
  logic [CH_W-1:0]     res [4];
  logic [CH_W-1:0]     out_r [4];
  logic                out_valid_r;

  chan_cfg_t           color_cfg, alpha_cfg;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_color_r   <= FC_ONE;
      dst_color_r   <= FC_ZERO;
      src_alpha_f_r <= FC_ONE;
      dst_alpha_f_r <= FC_ZERO;
      blend_op_r    <= OP_ADD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SRC_COLOR: src_color_r   <= cfg_data[FACTOR_W-1:0];
        REG_DST_COLOR: dst_color_r   <= cfg_data[FACTOR_W-1:0];
        REG_SRC_ALPHA: src_alpha_f_r <= cfg_data[FACTOR_W-1:0];
        REG_DST_ALPHA: dst_alpha_f_r <= cfg_data[FACTOR_W-1:0];
        REG_BLEND_OP:  blend_op_r    <= cfg_data[OP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      stage_vld_r <= accept;
      out_valid_r <= stage_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_r[0] <= in_src_red;
      s_r[1] <= in_src_green;
      s_r[2] <= in_src_blue;
      s_r[3] <= in_src_alpha;
      d_r[0] <= in_dst_red;
      d_r[1] <= in_dst_green;
      d_r[2] <= in_dst_blue;
      d_r[3] <= in_dst_alpha;
    end
    if (stage_vld_r) begin
      out_r <= res;
    end
  end

  assign color_cfg = '{src_factor: src_color_r, dst_factor: dst_color_r, op: blend_op_r};
  assign alpha_cfg = '{src_factor: src_alpha_f_r, dst_factor: dst_alpha_f_r, op: blend_op_r};

  for (genvar i = 0; i < 3; i++) begin : g_color
    pbu_channel u_chan (
      .cfg    (color_cfg),
      .sc     (s_r[i]),
      .dc     (d_r[i]),
      .sa     (s_r[3]),
      .da     (d_r[3]),
      .result (res[i])
    );
  end

  // alpha path: color codes read the alpha components
  pbu_channel u_alpha (
    .cfg    (alpha_cfg),
    .sc     (s_r[3]),
    .dc     (d_r[3]),
    .sa     (s_r[3]),
    .da     (d_r[3]),
    .result (res[3])
  );

  assign out_valid = out_valid_r;
  assign out_red   = out_r[0];
  assign out_green = out_r[1];
  assign out_blue  = out_r[2];
  assign out_alpha = out_r[3];

  `PBU_ASSERT_NXT(a_accept_stage, clk, rst_n, accept, stage_vld_r, "request not staged")
  `PBU_ASSERT_NXT(a_stage_out, clk, rst_n, stage_vld_r, out_valid, "staged request lost")
  `PBU_ASSERT_IMP(a_min_bound, clk, rst_n, out_valid && $past(blend_op_r) == OP_MIN, out_red <= $past(s_r[0]), "min above source")
  `PBU_ASSERT_IMP(a_sub_bound, clk, rst_n, out_valid && $past(blend_op_r) == OP_SUB, out_alpha <= $past(s_r[3]), "sub above source")

endmodule
`default_nettype wire
